// ===== rtl/core/otct_pkg.sv =====
// ----------------------------------------------------------------------------
// otct_pkg
// Shared widths, codes and structs of the ordered timeout connection table.
// ----------------------------------------------------------------------------
`default_nettype none

package otct_pkg;

  localparam int SLOTS_DEF  = 64;

  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int LINK_W     = 7;
  localparam int PORT_W     = 16;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;
  localparam int CNT_W      = 7;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // null marker for links, head and tail
  localparam logic [LINK_W-1:0] NIL_LINK = 7'd64;

  localparam logic [TMO_W-1:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [CNT_W-1:0] MAX_OPEN_RST = 7'd64;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OPENED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_CLOSED      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXPIRED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE_EXP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_OPEN_REJ    = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLOSE_INACT = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPEN = 1'd1;

  // write request to the link / entry memories
  typedef struct packed {
    logic              nxt_we;
    logic [SLOT_W-1:0] nxt_addr;
    logic [LINK_W-1:0] nxt_data;
    logic              prv_we;
    logic [SLOT_W-1:0] prv_addr;
    logic [LINK_W-1:0] prv_data;
    logic              ent_we;
    logic [SLOT_W-1:0] ent_addr;
    logic [PORT_W-1:0] ent_port;
    logic [TIME_W-1:0] ent_start;
  } mem_wr_t;

  // registered read data of one slot
  typedef struct packed {
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] start;
  } mem_rd_t;

  // one result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  count;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/otct_in_if.sv =====
// ----------------------------------------------------------------------------
// otct_in_if
// Command channel: kind, slot, port tag and current time.
// ----------------------------------------------------------------------------
`default_nettype none

interface otct_in_if import otct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [PORT_W-1:0] port_tag;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, kind, slot, port_tag, now_ms, input ready);
  modport sink   (input valid, kind, slot, port_tag, now_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/otct_out_if.sv =====
// ----------------------------------------------------------------------------
// otct_out_if
// Result channel: status, slot, port, open count and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface otct_out_if import otct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] out_slot;
  logic [PORT_W-1:0] out_port;
  logic [CNT_W-1:0]  open_count;
  logic              last;

  modport source (output valid, status, out_slot, out_port, open_count, last,
                  input ready);
  modport sink   (input valid, status, out_slot, out_port, open_count, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/otct_link_mem.sv =====
// ----------------------------------------------------------------------------
// otct_link_mem
// Per-slot next/prev links, port and start time; one write port per array,
// one shared read address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module otct_link_mem import otct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output mem_rd_t                rd
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [LINK_W-1:0] nxt_mem   [SLOTS];
  logic [LINK_W-1:0] prv_mem   [SLOTS];
  logic [PORT_W-1:0] port_mem  [SLOTS];
  logic [TIME_W-1:0] start_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.nxt_we) begin
      nxt_mem[wr.nxt_addr[IDX_W-1:0]] <= wr.nxt_data;
    end
    if (wr.prv_we) begin
      prv_mem[wr.prv_addr[IDX_W-1:0]] <= wr.prv_data;
    end
    if (wr.ent_we) begin
      port_mem[wr.ent_addr[IDX_W-1:0]]  <= wr.ent_port;
      start_mem[wr.ent_addr[IDX_W-1:0]] <= wr.ent_start;
    end
    rd.nxt   <= nxt_mem[rd_addr[IDX_W-1:0]];
    rd.prv   <= prv_mem[rd_addr[IDX_W-1:0]];
    rd.port  <= port_mem[rd_addr[IDX_W-1:0]];
    rd.start <= start_mem[rd_addr[IDX_W-1:0]];
  end

endmodule

`default_nettype wire

// ===== rtl/core/otct_cmp.sv =====
// ----------------------------------------------------------------------------
// otct_cmp
// Shared subtract-and-compare unit: gt = (a - b) mod 2^32 > c.
// ----------------------------------------------------------------------------
`default_nettype none

module otct_cmp import otct_pkg::*; (
  input  wire logic [TIME_W-1:0] a,
  input  wire logic [TIME_W-1:0] b,
  input  wire logic [TIME_W-1:0] c,
  output logic                   gt
);

  logic [TIME_W-1:0] diff;

  assign diff = a - b;
  assign gt   = diff > c;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_timeout_connection_table_top.sv =====
// ----------------------------------------------------------------------------
// ordered_timeout_connection_table_top
// Connection table whose active slots form a doubly linked list in open
// order. Channels: cmd (sink: open / close / tick), result (source), plus a
// plain config write port (timeout, max_open).
// Open: S_OPEN checks the slot and the room and loads the output register;
// S_OPEN_LINK follows when an older tail must be linked.
// Close: S_CLOSE does one memory read of the slot's links, then S_CLOSE_UPD
// does the unlink; a close of an inactive slot ends in S_CLOSE.
// Tick: each round (S_TICK_RD, S_TICK_CHK) reads the head slot and compares
// its age in the shared compare unit; an expired head is unlinked and the
// walk goes on; it ends in S_TICK_RD on an empty list, else in S_TICK_CHK.
// One command is in work at a time; cmd.ready is high only when idle.
// Results leave through one output register; a tick keeps each expired entry
// back one round so the final one can carry last. A stalled receiver holds
// the sequencer at its next emit point; nothing is dropped.
// Reset empties the list (head/tail null, count zero, all slots inactive) and
// loads timeout = 2000, max_open = 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_timeout_connection_table_top import otct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  otct_in_if.sink                    cmd,
  otct_out_if.source                 result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [LINK_W-1:0] SLOTS_L = LINK_W'(SLOTS);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_OPEN      = 3'd1;
  localparam logic [2:0] S_OPEN_LINK = 3'd2;
  localparam logic [2:0] S_CLOSE     = 3'd3;
  localparam logic [2:0] S_CLOSE_UPD = 3'd4;
  localparam logic [2:0] S_TICK_RD   = 3'd5;
  localparam logic [2:0] S_TICK_CHK  = 3'd6;

  logic [2:0] state, state_next;

  // config registers
  logic [TMO_W-1:0] timeout;
  logic [CNT_W-1:0] max_open;

  // list control
  logic [LINK_W-1:0] head, head_next;
  logic [LINK_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [SLOTS-1:0]  active;
  logic              act_set, act_clr;
  logic [IDX_W-1:0]  act_idx;

  // latched command
  logic [SLOT_W-1:0] slot_r;
  logic [PORT_W-1:0] port_r;
  logic [TIME_W-1:0] now_r;

  // tick walk: round counter and held-back expired entry
  logic [LINK_W-1:0] walk_k, walk_k_next;
  logic              pend_valid, pend_valid_next;
  res_t              pend, pend_next;

  // output register
  logic              out_valid;
  res_t              out_res;
  logic              ofree;
  logic              emit;
  res_t              emit_res;

  // memories and shared compare unit
  mem_wr_t           wr;
  mem_rd_t           rd;
  logic [SLOT_W-1:0] rd_addr;
  logic [TIME_W-1:0] cmp_a, cmp_b, cmp_c;
  logic              cmp_gt;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  cnt_dec;
  logic              slot_ok, slot_act;
  logic              head_ok, tail_ok, nxt_ok, prv_ok;

  otct_link_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  otct_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .c  (cmp_c),
    .gt (cmp_gt)
  );

  assign cmd.ready = (state == S_IDLE);
  assign ofree     = !out_valid || result.ready;

  assign limit    = (max_open > SLOTS_L) ? SLOTS_L : max_open;
  assign cnt_dec  = (count != '0) ? count - CNT_W'(1) : count;
  assign slot_ok  = {1'b0, slot_r} < SLOTS_L;
  assign slot_act = slot_ok ? active[slot_r[IDX_W-1:0]] : 1'b0;
  assign head_ok  = head < SLOTS_L;
  assign tail_ok  = tail < SLOTS_L;
  assign nxt_ok   = rd.nxt < SLOTS_L;
  assign prv_ok   = rd.prv < SLOTS_L;

  // tick walk reads the head, close reads the command's slot
  assign rd_addr = (state == S_TICK_RD || state == S_TICK_CHK) ? head[SLOT_W-1:0] : slot_r;

  // compare unit: room check on open, age check on tick
  always_comb begin
    if (state == S_OPEN) begin
      cmp_a = TIME_W'(limit);
      cmp_b = '0;
      cmp_c = TIME_W'(count);
    end else begin
      cmp_a = now_r;
      cmp_b = rd.start;
      cmp_c = TIME_W'(timeout);
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    walk_k_next     = walk_k;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    act_set         = 1'b0;
    act_clr         = 1'b0;
    act_idx         = slot_r[IDX_W-1:0];
    emit            = 1'b0;
    emit_res        = '0;
    wr              = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          walk_k_next     = '0;
          pend_valid_next = 1'b0;
          case (cmd.kind)
            KIND_OPEN:  state_next = S_OPEN;
            KIND_CLOSE: state_next = S_CLOSE;
            KIND_TICK:  state_next = S_TICK_RD;
            default:    state_next = S_IDLE;  // unused kind: no result
          endcase
        end
      end

      S_OPEN: begin
        if (ofree) begin
          emit            = 1'b1;
          emit_res.slot   = slot_r;
          emit_res.port   = port_r;
          emit_res.last   = 1'b1;
          if (!slot_ok || slot_act || !cmp_gt) begin
            emit_res.status = ST_OPEN_REJ;
            emit_res.count  = count;
            state_next      = S_IDLE;
          end else begin
            emit_res.status = ST_OPENED;
            emit_res.count  = count + CNT_W'(1);
            count_next      = count + CNT_W'(1);
            act_set         = 1'b1;
            wr.ent_we       = 1'b1;
            wr.ent_addr     = slot_r;
            wr.ent_port     = port_r;
            wr.ent_start    = now_r;
            wr.nxt_we       = 1'b1;
            wr.nxt_addr     = slot_r;
            wr.nxt_data     = NIL_LINK;
            wr.prv_we       = 1'b1;
            wr.prv_addr     = slot_r;
            wr.prv_data     = tail;
            if (tail_ok) begin
              state_next = S_OPEN_LINK;
            end else begin
              head_next  = {1'b0, slot_r};
              tail_next  = {1'b0, slot_r};
              state_next = S_IDLE;
            end
          end
        end
      end

      S_OPEN_LINK: begin
        wr.nxt_we   = 1'b1;
        wr.nxt_addr = tail[SLOT_W-1:0];
        wr.nxt_data = {1'b0, slot_r};
        tail_next   = {1'b0, slot_r};
        state_next  = S_IDLE;
      end

      S_CLOSE: begin
        if (!slot_act) begin
          if (ofree) begin
            emit            = 1'b1;
            emit_res.status = ST_CLOSE_INACT;
            emit_res.slot   = slot_r;
            emit_res.port   = '0;
            emit_res.count  = count;
            emit_res.last   = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          state_next = S_CLOSE_UPD;  // links of the slot arrive next cycle
        end
      end

      S_CLOSE_UPD: begin
        if (ofree) begin
          if (!prv_ok && !nxt_ok) begin
            head_next = NIL_LINK;
            tail_next = NIL_LINK;
          end else if (!prv_ok) begin
            head_next   = rd.nxt;
            wr.prv_we   = 1'b1;
            wr.prv_addr = rd.nxt[SLOT_W-1:0];
            wr.prv_data = NIL_LINK;
          end else if (!nxt_ok) begin
            tail_next   = rd.prv;
            wr.nxt_we   = 1'b1;
            wr.nxt_addr = rd.prv[SLOT_W-1:0];
            wr.nxt_data = NIL_LINK;
          end else begin
            wr.nxt_we   = 1'b1;
            wr.nxt_addr = rd.prv[SLOT_W-1:0];
            wr.nxt_data = rd.nxt;
            wr.prv_we   = 1'b1;
            wr.prv_addr = rd.nxt[SLOT_W-1:0];
            wr.prv_data = rd.prv;
          end
          act_clr         = 1'b1;
          count_next      = cnt_dec;
          emit            = 1'b1;
          emit_res.status = ST_CLOSED;
          emit_res.slot   = slot_r;
          emit_res.port   = rd.port;
          emit_res.count  = cnt_dec;
          emit_res.last   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_TICK_RD: begin
        if (!head_ok || walk_k == SLOTS_L) begin
          // list empty or walk bound hit: close out the tick
          if (ofree) begin
            emit = 1'b1;
            if (pend_valid) begin
              emit_res      = pend;
              emit_res.last = 1'b1;
            end else begin
              emit_res.status = ST_NONE_EXP;
              emit_res.count  = count;
              emit_res.last   = 1'b1;
            end
            pend_valid_next = 1'b0;
            state_next      = S_IDLE;
          end
        end else begin
          state_next = S_TICK_CHK;
        end
      end

      S_TICK_CHK: begin
        act_idx = head[IDX_W-1:0];
        if (ofree) begin
          if (!cmp_gt) begin
            emit = 1'b1;
            if (pend_valid) begin
              emit_res      = pend;
              emit_res.last = 1'b1;
            end else begin
              emit_res.status = ST_NONE_EXP;
              emit_res.count  = count;
              emit_res.last   = 1'b1;
            end
            pend_valid_next = 1'b0;
            state_next      = S_IDLE;
          end else begin
            // head expired: unlink it, hold its result back one round
            if (nxt_ok) begin
              head_next   = rd.nxt;
              wr.prv_we   = 1'b1;
              wr.prv_addr = rd.nxt[SLOT_W-1:0];
              wr.prv_data = NIL_LINK;
            end else begin
              head_next = NIL_LINK;
              tail_next = NIL_LINK;
            end
            act_clr    = 1'b1;
            count_next = cnt_dec;
            if (pend_valid) begin
              emit          = 1'b1;
              emit_res      = pend;
              emit_res.last = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_next.status = ST_EXPIRED;
            pend_next.slot   = head[SLOT_W-1:0];
            pend_next.port   = rd.port;
            pend_next.count  = cnt_dec;
            pend_next.last   = 1'b0;
            walk_k_next      = walk_k + LINK_W'(1);
            state_next       = S_TICK_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= NIL_LINK;
      tail       <= NIL_LINK;
      count      <= '0;
      active     <= '0;
      walk_k     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      timeout    <= TIMEOUT_RST;
      max_open   <= MAX_OPEN_RST;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      walk_k     <= walk_k_next;
      pend_valid <= pend_valid_next;
      if (act_set) begin
        active[act_idx] <= 1'b1;
      end else if (act_clr) begin
        active[act_idx] <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT:  timeout  <= cfg_wdata;
          CFG_MAX_OPEN: max_open <= cfg_wdata[CNT_W-1:0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      slot_r <= cmd.slot;
      port_r <= cmd.port_tag;
      now_r  <= cmd.now_ms;
    end
    pend <= pend_next;
    if (emit) begin
      out_res <= emit_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_res.status;
  assign result.out_slot   = out_res.slot;
  assign result.out_port   = out_res.port;
  assign result.open_count = out_res.count;
  assign result.last       = out_res.last;

  // ---- assertions ----
  // active bits and entry count track each other
  a_act_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(active) == int'(count))
    else $error("active bits disagree with entry count");

  // empty list exactly when head is null
  a_head_cnt: assert property (@(posedge clk) disable iff (rst)
    (head == NIL_LINK) == (count == '0))
    else $error("head null state disagrees with entry count");

  // a tick never leaves a held-back result behind
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending tick result left at idle");

  // an expiring round of a tick always steps the walk counter
  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK_CHK && state_next == S_TICK_RD)
      |=> walk_k == $past(walk_k) + LINK_W'(1))
    else $error("tick walk counter did not advance");

endmodule

`default_nettype wire

// ===== bench/tb_ordered_timeout_connection_table_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_timeout_connection_table_top
// Self-checking bench for the ordered timeout connection table. A directed
// command table comes first, then random open / close / tick traffic over
// several register settings. Every result transfer is checked against an
// in-bench model of the slot table and its linked list, or a typed expectation.
// ----------------------------------------------------------------------------
module tb_ordered_timeout_connection_table_top;
  import otct_pkg::*;

  localparam int SLOTS         = SLOTS_DEF;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 26;
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;   // block may still be busy after its last transfer
  localparam int N_DIR         = 22;

  // kind 3 carries no operation; the block must swallow it silently
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  otct_in_if  cmd_if ();
  otct_out_if res_if ();

  ordered_timeout_connection_table_top #(.SLOTS(SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Worst case is far below this: even 500 commands each sweeping 64 entries
  // behind the longest random receiver stalls stay under half of it.
  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Table model: slot memories, list ends, count and the two registers
  // --------------------------------------------------------------------------
  logic [LINK_W-1:0] link_nxt  [SLOTS];
  logic [LINK_W-1:0] link_prv  [SLOTS];
  logic [PORT_W-1:0] held_port [SLOTS];
  logic [TIME_W-1:0] opened_at [SLOTS];
  bit                live      [SLOTS];
  logic [LINK_W-1:0] chain_head;
  logic [LINK_W-1:0] chain_tail;
  logic [CNT_W-1:0]  live_count;
  logic [TMO_W-1:0]  cur_timeout;
  logic [CNT_W-1:0]  cur_max_open;

  res_t pending_results [$];   // results owed by the block, oldest first
  int   fail_count;

  // handshake pacing, shared between stimulus and receiver
  bit tx_gaps;
  bit rx_gaps;
  bit hold_request;

  logic [TIME_W-1:0] clock_ms;  // running wall time of the random traffic

  function automatic void reset_model();
    for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
    chain_head   = NIL_LINK;
    chain_tail   = NIL_LINK;
    live_count   = '0;
    cur_timeout  = TIMEOUT_RST;
    cur_max_open = MAX_OPEN_RST;
  endfunction

  function automatic void queue_result(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl,
                                       logic [PORT_W-1:0] pt, bit lst);
    res_t r;
    r.status = st;
    r.slot   = sl;
    r.port   = pt;
    r.count  = live_count;   // count after this result's change
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void unlink_slot(logic [SLOT_W-1:0] s);
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    p = link_prv[s];
    n = link_nxt[s];
    if (p >= SLOTS && n >= SLOTS) begin
      chain_head = NIL_LINK;
      chain_tail = NIL_LINK;
    end else if (p >= SLOTS) begin
      chain_head = n;
      link_prv[n[SLOT_W-1:0]] = NIL_LINK;
    end else if (n >= SLOTS) begin
      chain_tail = p;
      link_nxt[p[SLOT_W-1:0]] = NIL_LINK;
    end else begin
      link_nxt[p[SLOT_W-1:0]] = n;
      link_prv[n[SLOT_W-1:0]] = p;
    end
    live[s] = 1'b0;
    if (live_count > 0) live_count--;
  endfunction

  // Apply one accepted command to the model and queue the results it owes.
  function automatic void advance_table(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                        logic [PORT_W-1:0] port, logic [TIME_W-1:0] now);
    int unsigned       lim;
    int                k;
    logic [SLOT_W-1:0] h;
    logic [TIME_W-1:0] age;
    logic [PORT_W-1:0] p;
    res_t              r;
    case (kind)
      KIND_OPEN: begin
        lim = (cur_max_open > SLOTS) ? SLOTS : cur_max_open;
        if (live[slot] || live_count >= lim) begin
          queue_result(ST_OPEN_REJ, slot, port, 1'b1);
        end else begin
          live[slot]      = 1'b1;
          held_port[slot] = port;
          opened_at[slot] = now;
          link_prv[slot]  = chain_tail;
          link_nxt[slot]  = NIL_LINK;
          if (chain_tail >= SLOTS) begin
            chain_head = {1'b0, slot};
          end else begin
            link_nxt[chain_tail[SLOT_W-1:0]] = {1'b0, slot};
          end
          chain_tail = {1'b0, slot};
          live_count++;
          queue_result(ST_OPENED, slot, port, 1'b1);
        end
      end
      KIND_CLOSE: begin
        if (!live[slot]) begin
          queue_result(ST_CLOSE_INACT, slot, '0, 1'b1);
        end else begin
          p = held_port[slot];
          unlink_slot(slot);
          queue_result(ST_CLOSED, slot, p, 1'b1);
        end
      end
      KIND_TICK: begin
        // walk from the oldest entry, stop at the first one still young
        k = 0;
        while (k < SLOTS && chain_head < SLOTS) begin
          h   = chain_head[SLOT_W-1:0];
          age = now - opened_at[h];   // wraps mod 2^32
          if (age <= cur_timeout) break;
          p = held_port[h];
          unlink_slot(h);
          queue_result(ST_EXPIRED, h, p, 1'b0);
          k++;
        end
        if (k == 0) begin
          queue_result(ST_NONE_EXP, '0, '0, 1'b1);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // random slot that is (or is not) in the list; any slot if none qualifies
  function automatic logic [SLOT_W-1:0] find_slot(bit want_live);
    int unsigned start;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (live[(start + i) % SLOTS] == want_live) return SLOT_W'((start + i) % SLOTS);
    end
    return SLOT_W'(start);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void flag_error(string msg);
    if (fail_count < 100) $display("%0t ERROR %s", $realtime, msg);
    fail_count++;
  endfunction

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing awaited: status %0d slot %0d",
                             res_if.status, res_if.out_slot));
      end else begin
        want = pending_results.pop_front();
        check_field("status",     res_if.status,     want.status);
        check_field("out_slot",   res_if.out_slot,   want.slot);
        check_field("out_port",   res_if.out_port,   want.port);
        check_field("open_count", res_if.open_count, want.count);
        check_field("last",       res_if.last,       want.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stall bursts, or one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned burst;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // hold long enough for the command side to back up
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12);
        res_if.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Offer one command, wait for its transfer, then book its results. A typed
  // expectation replaces what the model books for that row.
  task automatic send_command(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                              logic [PORT_W-1:0] port, logic [TIME_W-1:0] now,
                              bit typed, res_t want);
    int n_held;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.kind     <= kind;
    cmd_if.slot     <= slot;
    cmd_if.port_tag <= port;
    cmd_if.now_ms   <= now;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    n_held = pending_results.size();
    advance_table(kind, slot, port, now);
    if (typed) begin
      while (pending_results.size() > n_held) void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  // Stop offering and wait until the block has delivered everything owed.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each write lowers cfg_we again before it returns, so back-to-back writes never collide on cfg_we.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) begin
      cur_timeout = data;
    end else begin
      cur_max_open = data[CNT_W-1:0];
    end
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: opens of free slots, closes of live ones and
  // ticks on a rising clock; a little noise with random fields and time.
  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    clock_ms += $urandom_range(0, cur_timeout / 6 + 4);
    if (pick < 8) begin
      send_command(KIND_W'($urandom_range(0, 3)), SLOT_W'($urandom), PORT_W'($urandom),
                   $urandom, 1'b0, '0);
    end else if (pick < 48) begin
      send_command(KIND_OPEN, find_slot(1'b0), PORT_W'($urandom), clock_ms, 1'b0, '0);
    end else if (pick < 72) begin
      send_command(KIND_CLOSE, find_slot(1'b1), PORT_W'($urandom), clock_ms, 1'b0, '0);
    end else begin
      if ($urandom_range(0, 4) == 0) clock_ms += cur_timeout;  // let a batch age out
      send_command(KIND_TICK, SLOT_W'($urandom), PORT_W'($urandom), clock_ms, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table (reset settings: timeout 2000, max 64 entries)
  // --------------------------------------------------------------------------
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] now;
    bit                typed;
    res_t              want;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR] = '{
    // empty list: tick finds nothing, close hits an idle slot
    '{KIND_TICK,   6'd0,  16'h0000, 32'h0000_0000, 1'b1,
      {ST_NONE_EXP, 6'd0, 16'h0000, 7'd0, 1'b1}},
    '{KIND_CLOSE,  6'd5,  16'h1111, 32'h0000_0000, 1'b1,
      {ST_CLOSE_INACT, 6'd5, 16'h0000, 7'd0, 1'b1}},
    // field extremes
    '{KIND_OPEN,   6'd0,  16'h0000, 32'h0000_0000, 1'b1,
      {ST_OPENED, 6'd0, 16'h0000, 7'd1, 1'b1}},
    '{KIND_OPEN,   6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      {ST_OPENED, 6'd63, 16'hFFFF, 7'd2, 1'b1}},
    // reopen of a live slot is refused, tag echoed
    '{KIND_OPEN,   6'd0,  16'h1234, 32'h0000_0005, 1'b1,
      {ST_OPEN_REJ, 6'd0, 16'h1234, 7'd2, 1'b1}},
    '{KIND_OPEN,   6'd10, 16'hAAAA, 32'h0000_0064, 1'b1,
      {ST_OPENED, 6'd10, 16'hAAAA, 7'd3, 1'b1}},
    // age equal to timeout does not expire; one more ms expires two
    '{KIND_TICK,   6'd0,  16'h0000, 32'd2000, 1'b1,
      {ST_NONE_EXP, 6'd0, 16'h0000, 7'd3, 1'b1}},
    '{KIND_TICK,   6'd33, 16'h5A5A, 32'd2001, 1'b0, '0},
    '{KIND_CLOSE,  6'd10, 16'h5555, 32'h0000_0000, 1'b1,
      {ST_CLOSED, 6'd10, 16'hAAAA, 7'd0, 1'b1}},
    '{KIND_UNUSED, 6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
    // unlink from middle, head and tail
    '{KIND_OPEN,   6'd1,  16'h0101, 32'd5000, 1'b0, '0},
    '{KIND_OPEN,   6'd2,  16'h0202, 32'd5001, 1'b0, '0},
    '{KIND_OPEN,   6'd3,  16'h0303, 32'd5002, 1'b0, '0},
    '{KIND_CLOSE,  6'd2,  16'h0000, 32'd5002, 1'b0, '0},
    '{KIND_OPEN,   6'd4,  16'h0404, 32'd5003, 1'b0, '0},
    '{KIND_CLOSE,  6'd1,  16'h0000, 32'd5003, 1'b0, '0},
    '{KIND_CLOSE,  6'd4,  16'h0000, 32'd5003, 1'b0, '0},
    '{KIND_CLOSE,  6'd4,  16'h0000, 32'd5003, 1'b1,
      {ST_CLOSE_INACT, 6'd4, 16'h0000, 7'd1, 1'b1}},
    // timestamps across the 32-bit wrap
    '{KIND_OPEN,   6'd20, 16'hBEEF, 32'hFFFF_FF00, 1'b0, '0},
    '{KIND_TICK,   6'd0,  16'h0000, 32'h0000_0100, 1'b0, '0},
    '{KIND_TICK,   6'd0,  16'h0000, 32'h0000_08D1, 1'b0, '0},
    '{KIND_TICK,   6'd0,  16'h0000, 32'h0000_08D1, 1'b1,
      {ST_NONE_EXP, 6'd0, 16'h0000, 7'd0, 1'b1}}
  };

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned       order [SLOTS];
    int unsigned       j;
    int unsigned       tmp;
    logic [TMO_W-1:0]  tmo;
    logic [CNT_W-1:0]  mo;

    cmd_if.valid    <= 1'b0;
    cmd_if.kind     <= KIND_OPEN;
    cmd_if.slot     <= '0;
    cmd_if.port_tag <= '0;
    cmd_if.now_ms   <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_TIMEOUT;
    cfg_wdata       <= '0;
    rst             <= 1'b1;
    fail_count   = 0;
    hold_request = 1'b0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    clock_ms     = '0;
    reset_model();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, reset register values
    for (int i = 0; i < N_DIR; i++) begin
      send_command(dir_tab[i].kind, dir_tab[i].slot, dir_tab[i].port, dir_tab[i].now,
                   dir_tab[i].typed, dir_tab[i].want);
    end

    // one entry allowed, zero timeout: full-table refusal, then expiry at 1 ms
    drain_results();
    write_reg(CFG_MAX_OPEN, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd0);
    clock_ms = $urandom;
    send_command(KIND_OPEN, 6'd7, 16'h0777, clock_ms, 1'b1,
                 {ST_OPENED, 6'd7, 16'h0777, 7'd1, 1'b1});
    send_command(KIND_OPEN, 6'd8, 16'h0888, clock_ms, 1'b1,
                 {ST_OPEN_REJ, 6'd8, 16'h0888, 7'd1, 1'b1});
    send_command(KIND_TICK, 6'd0, 16'h0000, clock_ms, 1'b1,
                 {ST_NONE_EXP, 6'd0, 16'h0000, 7'd1, 1'b1});
    send_command(KIND_TICK, 6'd0, 16'h0000, clock_ms + 32'd1, 1'b1,
                 {ST_EXPIRED, 6'd7, 16'h0777, 7'd0, 1'b1});

    // max_open beyond the slot count: fill every slot in random order, then
    // sweep all 64 in one tick while the receiver holds off and more
    // commands keep queuing behind it
    drain_results();
    write_reg(CFG_MAX_OPEN, 16'd127);
    clock_ms += 32'd2;
    for (int i = 0; i < SLOTS; i++) order[i] = i;
    for (int i = SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < SLOTS; i++) begin
      send_command(KIND_OPEN, SLOT_W'(order[i]), PORT_W'($urandom), clock_ms, 1'b0, '0);
    end
    send_command(KIND_OPEN, SLOT_W'($urandom), PORT_W'($urandom), clock_ms, 1'b0, '0);
    hold_request = 1'b1;
    send_command(KIND_TICK, 6'd0, 16'h0000, clock_ms + 32'd1, 1'b0, '0);
    repeat (6) random_item();

    // random traffic, fresh register settings per phase; last phase runs
    // without any idling on either side
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      case ($urandom_range(0, 3))
        0:       tmo = 16'hFFFF;
        1:       tmo = TMO_W'($urandom_range(0, 300));
        2:       tmo = TMO_W'($urandom);
        default: tmo = TIMEOUT_RST;
      endcase
      case ($urandom_range(0, 3))
        0:       mo = CNT_W'($urandom_range(1, 4));
        1:       mo = 7'd127;
        2:       mo = CNT_W'($urandom_range(1, 64));
        default: mo = MAX_OPEN_RST;
      endcase
      if (p == 0) begin
        tmo = 16'hFFFF;
        mo  = MAX_OPEN_RST;
      end
      write_reg(CFG_TIMEOUT, tmo);
      write_reg(CFG_MAX_OPEN, {9'd0, mo});
      if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
      tx_gaps = (p < RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_gaps = (p < RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 10) hold_request = 1'b1;
        random_item();
      end
    end

    // all commands taken: wait out the owed results plus a short settle
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
